// ===== hw/rtl/socks5_handshake_parser_assert.svh =====
// Assertion macros shared by the SOCKS5 handshake parser modules.
`ifndef SOCKS5_HANDSHAKE_PARSER_ASSERT_SVH
`define SOCKS5_HANDSHAKE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define S5HP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define S5HP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define S5HP_ASSERT(name, prop, msg)
`define S5HP_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== hw/rtl/s5hp_pkg.sv =====
// Types and protocol constants of the SOCKS5 handshake parser.
`timescale 1ns / 1ps

package s5hp_pkg;

  // Result kinds as they appear on the output
  typedef enum logic [2:0] {
    KIND_ADDR_BYTE = 3'd0,
    KIND_GREET_OK  = 3'd1,
    KIND_CONNECT   = 3'd2,
    KIND_ASSOC     = 3'd3,
    KIND_BAD_VER   = 3'd4,
    KIND_NO_METHOD = 3'd5,
    KIND_BAD_CMD   = 3'd6,
    KIND_BAD_ATYP  = 3'd7
  } s5hp_kind_t;

  // Parser phase; halted after an error until restart
  typedef enum logic [1:0] {
    PH_GREET = 2'd0,
    PH_REQ   = 2'd1,
    PH_HALT  = 2'd2
  } s5hp_phase_t;

  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] CMD_ASSOC     = 8'h03;
  localparam logic [7:0] METHOD_NOAUTH = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;
  localparam logic [8:0] HDR_LEN       = 9'd4;
  localparam logic [8:0] HDR_LEN_DOM   = 9'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } s5hp_item_t;

  typedef struct packed {
    s5hp_kind_t  kind;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [2:0]  addr_type;
    logic [7:0]  dst_len;
    logic [15:0] port;
    logic [8:0]  consumed_bytes;
  } s5hp_result_t;

endpackage

// ===== hw/rtl/s5hp_in_stage.sv =====
// Input register of the SOCKS5 handshake parser.
`timescale 1ns / 1ps

module s5hp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_restart,
  input  logic               advance,
  output logic               item_vld,
  output s5hp_pkg::s5hp_item_t item
);
  import s5hp_pkg::*;

  logic       vld_r, vld_nxt;
  s5hp_item_t item_r;
  logic       accept;

  // Stall only when a held word cannot move on this cycle
  assign in_stall = vld_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte <= in_data_byte;
      item_r.restart   <= in_restart;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== hw/rtl/s5hp_core.sv =====
// Parser state and per-word decode of the SOCKS5 handshake parser.
`timescale 1ns / 1ps
`include "socks5_handshake_parser_assert.svh"

module s5hp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  s5hp_pkg::s5hp_item_t   item,
  output logic                   res_vld,
  output s5hp_pkg::s5hp_result_t res
);
  import s5hp_pkg::*;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_VER,
    ACT_MCOUNT,
    ACT_METHOD,
    ACT_CMD,
    ACT_RSV,
    ACT_ATYP,
    ACT_DLEN,
    ACT_ADDR,
    ACT_PORT_HI,
    ACT_PORT_LO
  } act_t;

  s5hp_phase_t phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  mcount_r, mcount_nxt;
  logic        noauth_r, noauth_nxt;
  logic        assoc_r, assoc_nxt;
  logic [2:0]  atyp_r, atyp_nxt;
  logic [7:0]  alen_r, alen_nxt;
  logic [7:0]  acount_r, acount_nxt;
  logic [7:0]  port_hi_r, port_hi_nxt;

  logic [7:0]  b;
  act_t        act;
  logic        fail;
  s5hp_kind_t  fail_kind;
  logic        is_dom;
  logic        noauth_new;
  logic        last_method;
  logic        greet_ok;
  logic [8:0]  hdr;
  logic [8:0]  pos_inc;

  assign b           = item.data_byte;
  assign is_dom      = (atyp_r == ATYP_DOMAIN[2:0]);
  assign noauth_new  = noauth_r | (b == METHOD_NOAUTH);
  assign last_method = (pos_r >= ({1'b0, mcount_r} + 9'd1));
  assign greet_ok    = (act == ACT_METHOD) & last_method & noauth_new;
  assign hdr         = is_dom ? HDR_LEN_DOM : HDR_LEN;
  assign pos_inc     = pos_r + 9'd1;

  // Classify the word by phase and position
  always_comb begin
    act = ACT_NONE;
    if (!item.restart) begin
      case (phase_r)
        PH_GREET: begin
          if (pos_r == 9'd0) begin
            act = ACT_VER;
          end else if (pos_r == 9'd1) begin
            act = ACT_MCOUNT;
          end else begin
            act = ACT_METHOD;
          end
        end
        PH_REQ: begin
          if (pos_r == 9'd0) begin
            act = ACT_VER;
          end else if (pos_r == 9'd1) begin
            act = ACT_CMD;
          end else if (pos_r == 9'd2) begin
            act = ACT_RSV;
          end else if (pos_r == 9'd3) begin
            act = ACT_ATYP;
          end else if (is_dom && pos_r == 9'd4) begin
            act = ACT_DLEN;
          end else if (acount_r < alen_r) begin
            act = ACT_ADDR;
          end else if (pos_r == hdr + {1'b0, alen_r}) begin
            act = ACT_PORT_HI;
          end else begin
            act = ACT_PORT_LO;
          end
        end
        default: act = ACT_NONE;
      endcase
    end
  end

  // Error detection on the word that reveals it
  always_comb begin
    fail      = 1'b0;
    fail_kind = KIND_BAD_VER;
    case (act)
      ACT_VER: begin
        fail      = (b != SOCKS_VER);
        fail_kind = KIND_BAD_VER;
      end
      ACT_MCOUNT: begin
        fail      = (b == 8'd0);
        fail_kind = KIND_NO_METHOD;
      end
      ACT_METHOD: begin
        fail      = last_method & ~noauth_new;
        fail_kind = KIND_NO_METHOD;
      end
      ACT_CMD: begin
        fail      = !(b inside {CMD_CONNECT, CMD_ASSOC});
        fail_kind = KIND_BAD_CMD;
      end
      ACT_ATYP: begin
        fail      = !(b inside {ATYP_IPV4, ATYP_DOMAIN, ATYP_IPV6});
        fail_kind = KIND_BAD_ATYP;
      end
      default: begin
        fail      = 1'b0;
        fail_kind = KIND_BAD_VER;
      end
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (item.restart) begin
        phase_nxt = PH_GREET;
      end else begin
        case (phase_r)
          PH_GREET, PH_REQ: begin
            if (fail) begin
              phase_nxt = PH_HALT;
            end else if (greet_ok) begin
              phase_nxt = PH_REQ;
            end
          end
          PH_HALT: phase_nxt = PH_HALT;
          default: phase_nxt = PH_GREET;
        endcase
      end
    end
  end

  // Result of this word
  always_comb begin
    res     = '0;
    res_vld = 1'b0;
    if (fail) begin
      res_vld  = take;
      res.kind = fail_kind;
    end else begin
      case (act)
        ACT_METHOD: begin
          if (greet_ok) begin
            res_vld            = take;
            res.kind           = KIND_GREET_OK;
            res.consumed_bytes = pos_inc;
          end
        end
        ACT_ADDR: begin
          res_vld        = take;
          res.kind       = KIND_ADDR_BYTE;
          res.addr_byte  = b;
          res.addr_index = acount_r;
          res.addr_type  = atyp_r;
        end
        ACT_PORT_LO: begin
          res_vld            = take;
          res.kind           = assoc_r ? KIND_ASSOC : KIND_CONNECT;
          res.addr_type      = atyp_r;
          res.dst_len        = alen_r;
          res.port           = {port_hi_r, b};
          res.consumed_bytes = pos_inc;
        end
        default: res_vld = 1'b0;
      endcase
    end
  end

  // Counters and captured fields
  always_comb begin
    pos_nxt     = pos_r;
    mcount_nxt  = mcount_r;
    noauth_nxt  = noauth_r;
    assoc_nxt   = assoc_r;
    atyp_nxt    = atyp_r;
    alen_nxt    = alen_r;
    acount_nxt  = acount_r;
    port_hi_nxt = port_hi_r;
    if (take && item.restart) begin
      pos_nxt     = '0;
      mcount_nxt  = '0;
      noauth_nxt  = 1'b0;
      assoc_nxt   = 1'b0;
      atyp_nxt    = '0;
      alen_nxt    = '0;
      acount_nxt  = '0;
      port_hi_nxt = '0;
    end else if (take) begin
      case (act)
        ACT_VER: pos_nxt = 9'd1;
        ACT_MCOUNT: begin
          mcount_nxt = b;
          noauth_nxt = 1'b0;
          pos_nxt    = 9'd2;
        end
        ACT_METHOD: begin
          noauth_nxt = noauth_new;
          pos_nxt    = last_method ? 9'd0 : pos_inc;
        end
        ACT_CMD: begin
          assoc_nxt = (b == CMD_ASSOC);
          pos_nxt   = 9'd2;
        end
        ACT_RSV: pos_nxt = 9'd3;
        ACT_ATYP: begin
          atyp_nxt   = b[2:0];
          acount_nxt = '0;
          pos_nxt    = 9'd4;
          if (b == ATYP_IPV4) begin
            alen_nxt = IPV4_LEN;
          end else if (b == ATYP_IPV6) begin
            alen_nxt = IPV6_LEN;
          end else begin
            alen_nxt = 8'd0;
          end
        end
        ACT_DLEN: begin
          alen_nxt = b;
          pos_nxt  = 9'd5;
        end
        ACT_ADDR: begin
          acount_nxt = acount_r + 8'd1;
          pos_nxt    = pos_inc;
        end
        ACT_PORT_HI: begin
          port_hi_nxt = b;
          pos_nxt     = pos_inc;
        end
        ACT_PORT_LO: pos_nxt = 9'd0;
        default: pos_nxt = pos_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_GREET;
      pos_r     <= '0;
      mcount_r  <= '0;
      noauth_r  <= 1'b0;
      assoc_r   <= 1'b0;
      atyp_r    <= '0;
      alen_r    <= '0;
      acount_r  <= '0;
      port_hi_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      mcount_r  <= mcount_nxt;
      noauth_r  <= noauth_nxt;
      assoc_r   <= assoc_nxt;
      atyp_r    <= atyp_nxt;
      alen_r    <= alen_nxt;
      acount_r  <= acount_nxt;
      port_hi_r <= port_hi_nxt;
    end
  end

  `S5HP_ASSERT(a_greet_ok_enters_request, (res_vld && res.kind == KIND_GREET_OK) |=> (phase_r == PH_REQ), "greeting ok did not enter request phase")
  `S5HP_ASSERT(a_error_halts, (res_vld && (res.kind == KIND_BAD_VER || res.kind == KIND_NO_METHOD || res.kind == KIND_BAD_CMD || res.kind == KIND_BAD_ATYP)) |=> (phase_r == PH_HALT), "error did not halt parser")
  `S5HP_ASSERT_NEVER(a_addr_count_bound, acount_r > alen_r, "address count passed address length")
  `S5HP_ASSERT_NEVER(a_halt_silent, res_vld && phase_r == PH_HALT, "halted parser produced a result")

endmodule

// ===== hw/rtl/s5hp_out_stage.sv =====
// Result register of the SOCKS5 handshake parser.
`timescale 1ns / 1ps

module s5hp_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_vld,
  input  s5hp_pkg::s5hp_result_t res,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_kind,
  output logic [7:0]             out_addr_byte,
  output logic [7:0]             out_addr_index,
  output logic [2:0]             out_addr_type,
  output logic [7:0]             out_dst_len,
  output logic [15:0]            out_port,
  output logic [8:0]             out_consumed_bytes
);
  import s5hp_pkg::*;

  logic         vld_r, vld_nxt;
  s5hp_result_t res_r;

  // Slot is free when empty or being drained this cycle
  assign advance = ~vld_r | ~out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid          = vld_r;
  assign out_kind           = res_r.kind;
  assign out_addr_byte      = res_r.addr_byte;
  assign out_addr_index     = res_r.addr_index;
  assign out_addr_type      = res_r.addr_type;
  assign out_dst_len        = res_r.dst_len;
  assign out_port           = res_r.port;
  assign out_consumed_bytes = res_r.consumed_bytes;

endmodule

// ===== hw/rtl/socks5_handshake_parser.sv =====
// Top level of the SOCKS5 handshake parser.
`timescale 1ns / 1ps

// Byte-wide SOCKS5 greeting and request parser. Feed the client stream one
// word per cycle on the in_ channel; in_restart set on a word returns the
// parser to the greeting phase and the byte on that word is ignored. The
// parser takes one word every cycle unless the output stalls: a word is
// held in an input register, decoded against the parser state in one pass,
// and its result, if any, lands in the output register. Each word yields at
// most one result word: an address byte with its index, greeting ok, a
// CONNECT or UDP ASSOCIATE completion with the big-endian port, address
// length and message byte count, or an error kind on the word that reveals
// the error. After an error every word is dropped until a restart word. A
// stalled result only blocks the input once the input register also holds a
// word, so the two sides are decoupled by one register each.

module socks5_handshake_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_addr_byte,
  output logic [7:0]  out_addr_index,
  output logic [2:0]  out_addr_type,
  output logic [7:0]  out_dst_len,
  output logic [15:0] out_port,
  output logic [8:0]  out_consumed_bytes
);
  import s5hp_pkg::*;

  logic         advance;
  logic         item_vld;
  s5hp_item_t   item;
  logic         take;
  logic         res_vld;
  s5hp_result_t res;

  // Hold the incoming word until the result slot can take its outcome
  s5hp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .advance      (advance),
    .item_vld     (item_vld),
    .item         (item)
  );

  // Advance the parser state only when the word actually moves on
  assign take = item_vld & advance;

  s5hp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  s5hp_out_stage u_out_stage (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_vld            (res_vld),
    .res                (res),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_addr_byte      (out_addr_byte),
    .out_addr_index     (out_addr_index),
    .out_addr_type      (out_addr_type),
    .out_dst_len        (out_dst_len),
    .out_port           (out_port),
    .out_consumed_bytes (out_consumed_bytes)
  );

endmodule
